[hdl/jsu_pkg.sv]
// Package for the JSON string unescaper: modes, status codes, the command
// passed from the front end to the back end, and the decode and encode
// helper functions. No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX_HI  = 3'd3,
    MODE_WAIT_BS = 3'd4,
    MODE_WAIT_U  = 3'd5,
    MODE_HEX_LO  = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_DONE       = 3'd1,
    ST_EXPECTED   = 3'd2,
    ST_BAD_ESC    = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_UNTERM_ESC = 3'd5,
    ST_UNTERM_UNI = 3'd6,
    ST_UNTERM_STR = 3'd7
  } status_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  localparam logic [15:0] HiSurLo = 16'hD800;
  localparam logic [15:0] HiSurHi = 16'hDBFF;
  localparam logic [15:0] LoSurLo = 16'hDC00;
  localparam logic [15:0] LoSurHi = 16'hDFFF;
  localparam logic [20:0] SupBase = 21'h10000;
  localparam logic [20:0] Replacement = 21'h0FFFD;

  // One queue entry: up to four data bytes, then an optional closing result.
  typedef struct packed {
    logic [2:0]      nb;
    logic [3:0][7:0] bytes;
    logic            term;
    status_e         status;
    logic [LenW-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      nb;
    logic [3:0][7:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.val = 4'(c[3:0] + 4'd9);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic esc_t esc_decode(logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      ChQuote:  r.val = ChQuote;
      ChBslash: r.val = ChBslash;
      ChSlash:  r.val = ChSlash;
      8'h62:    r.val = 8'h08;
      8'h66:    r.val = 8'h0C;
      8'h6E:    r.val = ChLf;
      8'h72:    r.val = ChCr;
      8'h74:    r.val = ChTab;
      default: begin
        r.ok  = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.nb       = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.nb       = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SupBase) begin
      r.nb       = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.nb       = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[hdl/jsu_front.sv]
// Front end of the JSON string unescaper: parses one accepted text beat per
// cycle and turns it into at most one queue command. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  output logic              cmd_valid_o,
  output jsu_pkg::cmd_t     cmd_o
);

  jsu_pkg::mode_e          mode_q, mode_d, eff_mode;
  logic [11:0]             acc_q, acc_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [9:0]              hs_q, hs_d;
  logic [jsu_pkg::LenW-1:0] count_q, count_d, count_after;
  logic [jsu_pkg::LenW:0]  count_sum;
  logic                    pre_fffd;

  jsu_pkg::hex_t   hx;
  jsu_pkg::esc_t   esc;
  jsu_pkg::utf8_t  enc;
  logic [15:0]     acc_new;
  logic            is_hi_sur, is_lo_sur;
  logic [20:0]     cp_hi, cp_lo, cp_sel;
  logic [2:0]      nb_main;
  logic [3:0][7:0] mb;
  logic            term;
  jsu_pkg::status_e st;

  assign hx        = jsu_pkg::hex_decode(text_byte_i);
  assign esc       = jsu_pkg::esc_decode(text_byte_i);
  assign acc_new   = {acc_q, hx.val};
  assign is_hi_sur = acc_new inside {[jsu_pkg::HiSurLo:jsu_pkg::HiSurHi]};
  assign is_lo_sur = acc_new inside {[jsu_pkg::LoSurLo:jsu_pkg::LoSurHi]};
  assign cp_hi     = is_lo_sur ? jsu_pkg::Replacement : 21'(acc_new);
  assign cp_lo     = is_lo_sur ? jsu_pkg::SupBase + 21'({hs_q, acc_new[9:0]})
                               : jsu_pkg::Replacement;
  assign cp_sel    = (mode_q == jsu_pkg::MODE_HEX_LO) ? cp_lo : cp_hi;
  assign enc       = jsu_pkg::utf8_encode(cp_sel);

  // A pending high surrogate that is not followed by a low one is flushed as
  // U+FFFD, and the beat is then handled in the mode it falls back to.
  always_comb begin
    eff_mode = mode_q;
    pre_fffd = 1'b0;
    case (mode_q)
      jsu_pkg::MODE_WAIT_BS: begin
        if (end_of_text_i || text_byte_i != jsu_pkg::ChBslash) begin
          eff_mode = jsu_pkg::MODE_STR;
          pre_fffd = 1'b1;
        end
      end
      jsu_pkg::MODE_WAIT_U: begin
        if (end_of_text_i || text_byte_i != jsu_pkg::ChU) begin
          eff_mode = jsu_pkg::MODE_ESC;
          pre_fffd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output block: the command produced by this beat.
  always_comb begin
    nb_main = 3'd0;
    mb      = '0;
    term    = 1'b0;
    st      = jsu_pkg::ST_BYTE;
    case (eff_mode)
      jsu_pkg::MODE_STR: begin
        if (end_of_text_i) begin
          term = 1'b1;
          st   = jsu_pkg::ST_UNTERM_STR;
        end else if (text_byte_i == jsu_pkg::ChQuote) begin
          term = 1'b1;
          st   = jsu_pkg::ST_DONE;
        end else if (text_byte_i != jsu_pkg::ChBslash) begin
          nb_main = 3'd1;
          mb[0]   = text_byte_i;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (end_of_text_i) begin
          term = 1'b1;
          st   = jsu_pkg::ST_UNTERM_ESC;
        end else if (text_byte_i == jsu_pkg::ChU) begin
          nb_main = 3'd0;
        end else if (esc.ok) begin
          nb_main = 3'd1;
          mb[0]   = esc.val;
        end else begin
          term = 1'b1;
          st   = jsu_pkg::ST_BAD_ESC;
        end
      end
      jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
        if (end_of_text_i) begin
          term = 1'b1;
          st   = jsu_pkg::ST_UNTERM_UNI;
        end else if (!hx.ok) begin
          term = 1'b1;
          st   = jsu_pkg::ST_BAD_HEX;
        end else if (cnt_q == 2'd3 &&
                     !(mode_q == jsu_pkg::MODE_HEX_HI && is_hi_sur)) begin
          nb_main = enc.nb;
          mb      = enc.bytes;
        end
      end
      jsu_pkg::MODE_WAIT_BS, jsu_pkg::MODE_WAIT_U: ;
      default: begin
        if (end_of_text_i) begin
          term = 1'b1;
          st   = jsu_pkg::ST_EXPECTED;
        end else if (!(text_byte_i inside {jsu_pkg::ChSpace, jsu_pkg::ChTab,
                                            jsu_pkg::ChLf, jsu_pkg::ChCr,
                                            jsu_pkg::ChQuote})) begin
          term = 1'b1;
          st   = jsu_pkg::ST_EXPECTED;
        end
      end
    endcase

    if (pre_fffd) begin
      cmd_o.nb    = 3'd3 + nb_main;
      cmd_o.bytes = {mb[0], 8'hBD, 8'hBF, 8'hEF};
    end else begin
      cmd_o.nb    = nb_main;
      cmd_o.bytes = mb;
    end
    count_sum   = (jsu_pkg::LenW + 1)'(count_q) + (jsu_pkg::LenW + 1)'(cmd_o.nb);
    count_after = count_sum[jsu_pkg::LenW] ? '1 : count_sum[jsu_pkg::LenW-1:0];
    cmd_o.term   = term;
    cmd_o.status = st;
    cmd_o.len    = (term && st == jsu_pkg::ST_DONE) ? count_after : '0;
    cmd_valid_o  = term || (cmd_o.nb != 3'd0);
  end

  // Next-state block.
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    hs_d    = hs_q;
    count_d = count_q;
    if (accept_i) begin
      count_d = count_after;
      case (eff_mode)
        jsu_pkg::MODE_STR: begin
          if (!end_of_text_i && text_byte_i == jsu_pkg::ChBslash) begin
            mode_d = jsu_pkg::MODE_ESC;
          end else begin
            mode_d = jsu_pkg::MODE_STR;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (!end_of_text_i && text_byte_i == jsu_pkg::ChU) begin
            mode_d = jsu_pkg::MODE_HEX_HI;
            acc_d  = '0;
            cnt_d  = '0;
          end else begin
            mode_d = jsu_pkg::MODE_STR;
          end
        end
        jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
          acc_d = acc_new[11:0];
          if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d = '0;
            if (mode_q == jsu_pkg::MODE_HEX_HI && is_hi_sur) begin
              hs_d   = acc_new[9:0];
              mode_d = jsu_pkg::MODE_WAIT_BS;
            end else begin
              mode_d = jsu_pkg::MODE_STR;
            end
          end
        end
        jsu_pkg::MODE_WAIT_BS: mode_d = jsu_pkg::MODE_WAIT_U;
        jsu_pkg::MODE_WAIT_U: begin
          mode_d = jsu_pkg::MODE_HEX_LO;
          acc_d  = '0;
          cnt_d  = '0;
        end
        default: begin
          mode_d = jsu_pkg::MODE_IDLE;
          if (!end_of_text_i && text_byte_i == jsu_pkg::ChQuote) begin
            mode_d  = jsu_pkg::MODE_STR;
            acc_d   = '0;
            cnt_d   = '0;
            hs_d    = '0;
            count_d = '0;
          end
        end
      endcase
      if (term) begin
        mode_d  = jsu_pkg::MODE_IDLE;
        acc_d   = '0;
        cnt_d   = '0;
        hs_d    = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jsu_pkg::MODE_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hs_q    <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
      count_q <= count_d;
    end
  end

endmodule

[hdl/jsu_fifo.sv]
// Command queue between the front end and the back end of the unescaper.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  jsu_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output jsu_pkg::cmd_t rd_data_o
);

  jsu_pkg::cmd_t                 entries_q [jsu_pkg::QDepth];
  logic [jsu_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o    = (cnt_q == jsu_pkg::QCntW'(jsu_pkg::QDepth));
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/jsu_back.sv]
// Back end of the unescaper: expands one queue command into result beats,
// one beat per cycle while pop is high. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    status_o,
  output logic [15:0]   string_length_o,
  output logic          last_o
);

  jsu_pkg::cmd_t cmd_q;
  logic          busy_q;
  logic [1:0]    idx_q;
  logic [2:0]    total;
  logic          at_last, is_data;
  logic [31:0]   len_ext;

  assign total     = cmd_q.nb + 3'(cmd_q.term);
  assign at_last   = ({1'b0, idx_q} == total - 3'd1);
  assign is_data   = ({1'b0, idx_q} < cmd_q.nb);
  assign cmd_pop_o = cmd_valid_i && (!busy_q || (pop && at_last));
  assign len_ext   = 32'(cmd_q.len);

  assign empty           = !busy_q;
  assign out_byte_o      = is_data ? cmd_q.bytes[idx_q] : 8'h00;
  assign status_o        = is_data ? jsu_pkg::ST_BYTE : cmd_q.status;
  assign string_length_o = is_data ? 16'h0000 : len_ext[15:0];
  assign last_o          = at_last;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (cmd_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q && pop) begin
        if (at_last) begin
          busy_q <= 1'b0;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // A closing result is always the final beat of its input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != jsu_pkg::ST_BYTE) |-> last_o)
    else $error("closing result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != jsu_pkg::ST_DONE) |-> (string_length_o == 16'h0000))
    else $error("length shown on a result that is not done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop) |=> (busy_q && $stable(idx_q)))
    else $error("result index moved while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (total != 3'd0 && {1'b0, idx_q} < total))
    else $error("result index outside the command");

endmodule

[hdl/json_string_unescape_top.sv]
// Channel   Handshake          Beat payload
// input     push / full        text_byte_i, end_of_text_i
// result    empty / pop        out_byte_o, status_o, string_length_o, last_o
//
// One input beat is taken per cycle while full is low; the front end parses
// it in that cycle. A beat yields up to four results, one result per cycle
// while pop is high; a four-entry command queue absorbs the burst. A beat's
// command is registered in the queue, then in the back end, before its first
// result is on the result ports. Reset clears the parser to idle and empties
// the queue; full stays high only while the queue holds four commands.
`timescale 1ns / 1ps

module json_string_unescape_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic [15:0] string_length_o,
  output logic        last_o
);

  logic          accept;
  logic          front_valid;
  jsu_pkg::cmd_t front_cmd;
  logic          q_valid;
  jsu_pkg::cmd_t q_cmd;
  logic          q_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cmd_valid_o   (front_valid),
    .cmd_o         (front_cmd)
  );

  jsu_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && front_valid),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_cmd)
  );

  jsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .cmd_pop_o       (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .string_length_o (string_length_o),
    .last_o          (last_o)
  );

endmodule
